// ===== src/assert_macros.svh =====
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== src/vpt_pkg.sv =====
// Shared constants and controller/datapath interface types of the tokenizer.
package vpt_pkg;

    localparam int MAX_ENTRIES_DEF   = 4096;
    localparam int MAX_ENTRY_LEN_DEF = 16;

    localparam int IDX_W   = 12;
    localparam int POS_W   = 4;
    localparam int LEN_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 13;
    localparam int TOK_W   = 12;

    localparam int IDX_LSB  = 0;
    localparam int POS_LSB  = IDX_LSB + IDX_W;
    localparam int LEN_LSB  = POS_LSB + POS_W;
    localparam int CHAR_LSB = LEN_LSB + LEN_W;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    localparam logic STATUS_MATCH    = 1'b0;
    localparam logic STATUS_NO_MATCH = 1'b1;

    typedef struct packed {
        logic load;
        logic append;
        logic start_scan;
        logic scan;
        logic emit;
        logic mark_last;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic scan_done;
        logic out_free;
        logic rest_empty;
    } dp_status_t;

endpackage

// ===== src/vpt_datapath.sv =====
// Tokenizer datapath: vocabulary memories, text window, entry compare and result register.
`include "assert_macros.svh"

module vpt_datapath #(
    parameter int MAX_ENTRIES   = vpt_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_ENTRY_LEN = vpt_pkg::MAX_ENTRY_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vpt_pkg::dp_cmd_t              cmd_i,
    output vpt_pkg::dp_status_t           sts_o,
    input  logic [vpt_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [vpt_pkg::COUNT_W-1:0]   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vpt_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = (MAX_ENTRY_LEN > 1) ? $clog2(MAX_ENTRY_LEN) : 1;
    localparam int FW = $clog2(MAX_ENTRY_LEN + 1);

    logic [vpt_pkg::IDX_W-1:0]  in_idx;
    logic [vpt_pkg::POS_W-1:0]  in_pos;
    logic [vpt_pkg::LEN_W-1:0]  in_len;
    logic [vpt_pkg::CHAR_W-1:0] in_char;
    logic [vpt_pkg::CHAR_W-1:0] in_lower;
    logic                       load_ok;

    // One row per entry, one byte lane per character position.
    logic [MAX_ENTRY_LEN-1:0][7:0] chars_mem [MAX_ENTRIES];
    logic [vpt_pkg::LEN_W-1:0]     len_mem   [MAX_ENTRIES];

    logic [MAX_ENTRY_LEN-1:0][7:0] rd_row_reg;
    logic [vpt_pkg::LEN_W-1:0]     rd_len_reg;
    logic [EW-1:0]                 rd_addr;
    logic [EW-1:0]                 rd_addr_reg;
    logic                          rd_valid_reg;
    logic [CW-1:0]                 scan_cnt_reg;
    logic [CW-1:0]                 scan_start;

    logic [vpt_pkg::COUNT_W-1:0]   vocab_count_reg;

    logic [7:0]    win_reg   [MAX_ENTRY_LEN];
    logic [7:0]    win_shift [MAX_ENTRY_LEN];
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] rest;

    logic          mismatch;
    logic          entry_hit;
    logic          exhausted;

    logic [EW-1:0] res_index_reg;
    logic [FW-1:0] res_drop_reg;
    logic          res_nomatch_reg;

    logic [vpt_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic                         m_tuser_reg;
    logic                         m_tlast_reg;
    logic                         m_tvalid_reg;

    assign in_idx  = s_tdata[vpt_pkg::IDX_LSB  +: vpt_pkg::IDX_W];
    assign in_pos  = s_tdata[vpt_pkg::POS_LSB  +: vpt_pkg::POS_W];
    assign in_len  = s_tdata[vpt_pkg::LEN_LSB  +: vpt_pkg::LEN_W];
    assign in_char = s_tdata[vpt_pkg::CHAR_LSB +: vpt_pkg::CHAR_W];

    assign in_lower = (in_char inside {[8'h41:8'h5A]}) ? in_char + 8'h20 : in_char;
    assign load_ok  = (32'(in_idx) < MAX_ENTRIES) && (32'(in_pos) < MAX_ENTRY_LEN);

    always_ff @(posedge aclk) begin
        if (cmd_i.load && load_ok) begin
            chars_mem[EW'(in_idx)][PW'(in_pos)] <= in_char;
            len_mem[EW'(in_idx)]                <= in_len;
        end
    end

    assign rd_addr = EW'(scan_cnt_reg - CW'(1));

    always_ff @(posedge aclk) begin
        rd_row_reg <= chars_mem[rd_addr];
        rd_len_reg <= len_mem[rd_addr];
    end

    // Counts above the vocabulary size scan the whole vocabulary.
    assign scan_start = (32'(vocab_count_reg) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                              : CW'(vocab_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vocab_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            vocab_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else if (cmd_i.start_scan) begin
            scan_cnt_reg <= scan_start;
            rd_valid_reg <= 1'b0;
        end else if (cmd_i.scan && scan_cnt_reg != '0) begin
            scan_cnt_reg <= scan_cnt_reg - CW'(1);
            rd_valid_reg <= 1'b1;
        end else begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr;
    end

    always_comb begin
        mismatch = 1'b0;
        for (int k = 0; k < MAX_ENTRY_LEN; k++) begin
            if (k < int'(rd_len_reg) && rd_row_reg[k] != win_reg[k]) begin
                mismatch = 1'b1;
            end
        end
    end

    assign entry_hit = rd_valid_reg && !mismatch && rd_len_reg != '0
                       && int'(rd_len_reg) <= MAX_ENTRY_LEN
                       && int'(rd_len_reg) <= int'(fill_reg);
    assign exhausted = (scan_cnt_reg == '0) && !rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd_i.scan && (entry_hit || exhausted)) begin
            res_nomatch_reg <= !entry_hit;
            res_index_reg   <= entry_hit ? rd_addr_reg : '0;
            res_drop_reg    <= entry_hit ? FW'(rd_len_reg) : FW'(1);
        end
    end

    assign rest = fill_reg - res_drop_reg;

    always_comb begin
        for (int k = 0; k < MAX_ENTRY_LEN; k++) begin
            if (k + int'(res_drop_reg) < MAX_ENTRY_LEN) begin
                win_shift[k] = win_reg[PW'(k + int'(res_drop_reg))];
            end else begin
                win_shift[k] = 8'h00;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.emit) begin
            win_reg <= win_shift;
        end else if (cmd_i.append && 32'(fill_reg) < MAX_ENTRY_LEN) begin
            win_reg[PW'(fill_reg)] <= in_lower;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd_i.emit) begin
            fill_reg <= rest;
        end else if (cmd_i.append && 32'(fill_reg) < MAX_ENTRY_LEN) begin
            fill_reg <= fill_reg + FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd_i.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.emit) begin
            m_tdata_reg <= vpt_pkg::M_DATA_W'(vpt_pkg::TOK_W'(res_index_reg));
            m_tuser_reg <= res_nomatch_reg ? vpt_pkg::STATUS_NO_MATCH
                                           : vpt_pkg::STATUS_MATCH;
            m_tlast_reg <= cmd_i.mark_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign sts_o.full       = (32'(fill_reg) == MAX_ENTRY_LEN);
    assign sts_o.scan_done  = entry_hit || exhausted;
    assign sts_o.out_free   = !m_tvalid_reg || m_tready;
    assign sts_o.rest_empty = (rest == '0);

    `ASSERT_PROP(a_fill_bound, aclk, aresetn, 32'(fill_reg) <= MAX_ENTRY_LEN, "window overfilled")
    `ASSERT_PROP(a_drop_fits, aclk, aresetn, cmd_i.emit |-> (res_drop_reg <= fill_reg && res_drop_reg != '0), "bad drop")
    `ASSERT_PROP(a_emit_shows, aclk, aresetn, cmd_i.emit |=> m_tvalid_reg, "result lost")

endmodule

// ===== src/vpt_ctrl.sv =====
// Tokenizer controller: request acceptance, scan sequencing and result hand-off.
`include "assert_macros.svh"

module vpt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  logic                s_tlast,
    output vpt_pkg::dp_cmd_t    cmd_o,
    input  vpt_pkg::dp_status_t sts_i
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t st_reg, st_next;
    logic   flush_reg, flush_next;
    logic   acc;

    assign s_tready = (st_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        st_next    = st_reg;
        flush_next = flush_reg;
        cmd_o      = '0;
        case (st_reg)
            ST_IDLE: begin
                if (acc && s_tuser == vpt_pkg::CMD_TEXT) begin
                    cmd_o.append = 1'b1;
                    flush_next   = s_tlast;
                    st_next      = ST_CHECK;
                end else if (acc) begin
                    cmd_o.load = 1'b1;
                end
            end
            ST_CHECK: begin
                if (flush_reg || sts_i.full) begin
                    cmd_o.start_scan = 1'b1;
                    st_next          = ST_SCAN;
                end else begin
                    st_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd_o.scan = 1'b1;
                if (sts_i.scan_done) begin
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts_i.out_free) begin
                    cmd_o.emit      = 1'b1;
                    cmd_o.mark_last = flush_reg && sts_i.rest_empty;
                    // A flush keeps matching until the window is empty.
                    if (flush_reg && !sts_i.rest_empty) begin
                        cmd_o.start_scan = 1'b1;
                        st_next          = ST_SCAN;
                    end else begin
                        st_next = ST_IDLE;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            flush_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            flush_reg <= flush_next;
        end
    end

    `ASSERT_PROP(a_emit_free, aclk, aresetn, cmd_o.emit |-> sts_i.out_free, "emit into busy output")
    `ASSERT_PROP(a_text_check, aclk, aresetn, (acc && s_tuser == vpt_pkg::CMD_TEXT) |=> st_reg == ST_CHECK, "text request not checked")
    `ASSERT_PROP(a_flush_cont, aclk, aresetn, (cmd_o.emit && flush_reg && !sts_i.rest_empty) |=> st_reg == ST_SCAN, "flush stopped early")

endmodule

// ===== src/vocab_prefix_tokenizer.sv =====
// Top level of the vocabulary prefix tokenizer.
//
//  channel  direction  handshake                  contents
//  s_       in         s_tvalid / s_tready        load or text request
//  m_       out        m_tvalid / m_tready        token result
//  cfg_     in         cfg_valid / cfg_ready      vocab_count register
//
// A load request leaves the controller idle; a non-last text request that fills no
// window goes through the check state back to idle. Each token scans entries from
// min(vocab_count, entries)-1 down, one entry per cycle through the single read port
// of the vocabulary row memory, and the emit step hands it to the output register.
// Reset clears the window fill, the count register and the control; the vocabulary
// memories are not cleared. A stalled output holds the next token in the emit step.
module vocab_prefix_tokenizer #(
    parameter int MAX_ENTRIES   = vpt_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_ENTRY_LEN = vpt_pkg::MAX_ENTRY_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index[11:0], char_pos[15:12], entry_len[20:16], char_value[28:21], zeros
    input  logic [vpt_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // token_index[11:0], zeros
    output logic [vpt_pkg::M_DATA_W-1:0]  m_tdata,
    // status
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vpt_pkg::COUNT_W-1:0]   cfg_data
);

    vpt_pkg::dp_cmd_t    cmd;
    vpt_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    vpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cmd_o    (cmd),
        .sts_i    (sts)
    );

    vpt_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (cmd),
        .sts_o     (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== test/vocab_prefix_tokenizer_tb.sv =====
// Self-checking testbench for the vocabulary prefix tokenizer: loads, text strings, token checks.
module vocab_prefix_tokenizer_tb;

    localparam int NUM_ENTRIES = vpt_pkg::MAX_ENTRIES_DEF;
    localparam int ENTRY_LEN   = vpt_pkg::MAX_ENTRY_LEN_DEF;
    localparam int IDX_W       = vpt_pkg::IDX_W;
    localparam int POS_W       = vpt_pkg::POS_W;
    localparam int LEN_W       = vpt_pkg::LEN_W;
    localparam int CHAR_W      = vpt_pkg::CHAR_W;
    localparam int COUNT_W     = vpt_pkg::COUNT_W;
    localparam int TOK_W       = vpt_pkg::TOK_W;
    localparam int S_DATA_W    = vpt_pkg::S_DATA_W;
    localparam int M_DATA_W    = vpt_pkg::M_DATA_W;
    localparam int SMALL_VOCAB = 16;
    localparam int TEXT_ITEMS  = 90;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 12;

    typedef struct {
        logic [TOK_W-1:0] token;
        logic             status;
        logic             last;
    } token_t;

    class token_scoreboard;
        logic [CHAR_W-1:0]  vocab_char [NUM_ENTRIES][ENTRY_LEN];
        logic [LEN_W-1:0]   vocab_len [NUM_ENTRIES];
        logic [CHAR_W-1:0]  window [ENTRY_LEN];
        int                 fill;
        int                 entry_count;
        token_t             pending [$];
        int                 mismatches;

        function void reset_state();
            fill = 0;
            entry_count = 0;
            mismatches = 0;
            pending.delete();
        endfunction

        function bit entry_hits(int e);
            int len;
            len = vocab_len[e];
            if (len == 0 || len > ENTRY_LEN || len > fill) return 0;
            for (int k = 0; k < len; k++)
                if (vocab_char[e][k] != window[k]) return 0;
            return 1;
        endfunction

        // Queues the highest hit's token and drops its chars; with no hit, a miss and one char.
        function void take_token();
            token_t t;
            int     n;
            int     drop;
            n = (entry_count > NUM_ENTRIES) ? NUM_ENTRIES : entry_count;
            drop = 1;
            t.token = '0;
            t.status = vpt_pkg::STATUS_NO_MATCH;
            t.last = 1'b0;
            for (int e = n - 1; e >= 0; e--) begin
                if (entry_hits(e)) begin
                    t.token = e[TOK_W-1:0];
                    t.status = vpt_pkg::STATUS_MATCH;
                    drop = vocab_len[e];
                    break;
                end
            end
            if (drop > fill) drop = fill;
            for (int k = 0; k < ENTRY_LEN; k++)
                window[k] = (k + drop < ENTRY_LEN) ? window[k + drop] : '0;
            fill -= drop;
            pending.push_back(t);
        endfunction

        function void note_request(logic cmd, logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos,
                                   logic [LEN_W-1:0] len, logic [CHAR_W-1:0] ch, logic last);
            int produced;
            produced = 0;
            if (cmd == vpt_pkg::CMD_LOAD) begin
                vocab_char[idx][pos] = ch;
                vocab_len[idx] = len;
                return;
            end
            if (ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'h20;
            if (fill < ENTRY_LEN) begin
                window[fill] = ch;
                fill++;
            end
            if (last) begin
                while (fill > 0 && produced < ENTRY_LEN) begin
                    take_token();
                    produced++;
                end
                if (produced > 0) pending[pending.size() - 1].last = 1'b1;
            end else if (fill >= ENTRY_LEN) begin
                take_token();
            end
        endfunction

        function void check_token(logic [TOK_W-1:0] token, logic status, logic last);
            token_t t;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token %0d status %0b last %0b", token, status, last);
                return;
            end
            t = pending.pop_front();
            if (t.token !== token || t.status !== status || t.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("token mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             t.token, t.status, t.last, token, status, last);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data;

    token_scoreboard sb;
    int  cycles;
    int  hold_off;
    bit  quiet;
    int  text_sent;

    vocab_prefix_tokenizer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Token receiver with random stalls and the long hold-off requested by the stimulus.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_token(m_tdata[TOK_W-1:0], m_tuser, m_tlast);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    task automatic send_request(logic cmd, logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos,
                                logic [LEN_W-1:0] len, logic [CHAR_W-1:0] ch, logic last,
                                bit no_gap);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tlast <= last;
        s_tdata <= {3'b000, ch, len, pos, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(cmd, idx, pos, len, ch, last);
        if (cmd == vpt_pkg::CMD_TEXT) text_sent++;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.entry_count = value;
    endtask

    // Only the positions that a scan compares are written; a bad length needs one request.
    task automatic load_entry(int e, int len, logic [CHAR_W-1:0] chars [ENTRY_LEN], bit no_gap);
        int n;
        n = (len < 1 || len > ENTRY_LEN) ? 1 : len;
        for (int p = 0; p < n; p++)
            send_request(vpt_pkg::CMD_LOAD, e[IDX_W-1:0], p[POS_W-1:0], len[LEN_W-1:0],
                         chars[p], 1'($urandom_range(0, 1)), no_gap);
    endtask

    function logic [CHAR_W-1:0] text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return CHAR_W'(8'h61 + $urandom_range(0, 3));
        if (r < 85) return CHAR_W'(8'h41 + $urandom_range(0, 3));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic load_random_entry(int e, int max_len, bit no_gap);
        logic [CHAR_W-1:0] c [ENTRY_LEN];
        int len;
        len = $urandom_range(1, max_len);
        for (int p = 0; p < ENTRY_LEN; p++)
            c[p] = ($urandom_range(0, 9) == 0) ? CHAR_W'(8'h41 + $urandom_range(0, 3))
                                               : CHAR_W'(8'h61 + $urandom_range(0, 3));
        load_entry(e, len, c, no_gap);
    endtask

    task automatic send_string(int n);
        for (int i = 0; i < n; i++)
            send_request(vpt_pkg::CMD_TEXT, IDX_W'($urandom), POS_W'($urandom),
                         LEN_W'($urandom), text_char(), i == n - 1, 0);
    endtask

    task automatic send_text(string s, bit last);
        for (int i = 0; i < s.len(); i++)
            send_request(vpt_pkg::CMD_TEXT, '0, '0, '0, s[i], last && (i == s.len() - 1), 0);
    endtask

    initial begin
        logic [CHAR_W-1:0] c [ENTRY_LEN];
        sb = new();
        sb.reset_state();
        hold_off = 0;
        quiet = 0;
        text_sent = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With an empty vocabulary every character comes back as a miss.
        send_text("Ab", 1);
        write_count('0);
        send_text("x", 1);

        // Small vocabulary: single letters, nested prefixes, bad lengths, uppercase bytes.
        for (int e = 0; e < 4; e++) begin
            foreach (c[p]) c[p] = CHAR_W'($urandom);
            c[0] = CHAR_W'(8'h61 + e);
            load_entry(e, 1, c, 0);
        end
        foreach (c[p]) c[p] = CHAR_W'($urandom);
        c[0] = "a"; c[1] = "b";
        load_entry(4, 2, c, 0);
        c[2] = "c";
        load_entry(5, 3, c, 0);
        load_entry(6, 0, c, 0);
        load_entry(7, 17, c, 0);
        load_entry(8, 31, c, 0);
        c[0] = "A"; c[1] = "B"; c[2] = "D";
        load_entry(9, 3, c, 0);
        foreach (c[p]) c[p] = (p % 2) ? "b" : "a";
        load_entry(10, 16, c, 0);
        for (int e = 11; e < SMALL_VOCAB; e++) load_random_entry(e, 6, 0);
        write_count(COUNT_W'(SMALL_VOCAB));

        send_text("ABC", 1);
        send_text("abababababababab", 0);
        send_text("abcdabcdabcdabcdd", 0);
        send_text("cab", 1);
        send_text("Z", 1);
        send_request(vpt_pkg::CMD_TEXT, '1, '1, '1, 8'hFF, 0, 0);
        send_request(vpt_pkg::CMD_TEXT, '0, '0, '0, 8'h00, 0, 0);
        send_text("@[`{", 1);
        write_count(COUNT_W'(1));
        send_text("aab", 1);

        // Random strings; the first long one meets a receiver that holds off.
        write_count(COUNT_W'(SMALL_VOCAB));
        hold_off = 400;
        send_string(24);
        while (text_sent < TEXT_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) begin
                drain();
                load_random_entry($urandom_range(0, SMALL_VOCAB - 1), 6, 0);
            end
            if ($urandom_range(0, 4) == 0)
                write_count(COUNT_W'($urandom_range(1, SMALL_VOCAB)));
            if ($urandom_range(0, 9) == 0) write_count(COUNT_W'(SMALL_VOCAB));
            send_string($urandom_range(1, 12));
        end
        quiet = 0;

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== vocab_prefix_tokenizer.f =====
+incdir+src
src/vpt_pkg.sv
src/vpt_datapath.sv
src/vpt_ctrl.sv
src/vocab_prefix_tokenizer.sv
test/vocab_prefix_tokenizer_tb.sv
